// File: rtl/chkv_pkg.sv
// chkv_pkg: shared types, constants and the key mixing steps for the hash table
// no dependencies
package chkv_pkg;

    localparam int BUCKETS = 1024;
    localparam int ENTRIES = 64;
    localparam int BW = $clog2(BUCKETS);
    localparam int SW = $clog2(ENTRIES + 1);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [SW-1:0] NIL_SLOT = SW'(ENTRIES);
    localparam logic [31:0] MIX_MUL = 32'h045d9f3b;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    // unused code, treated as no operation
    localparam logic [1:0] OP_NONE   = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] key;
        logic [31:0] value_in;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [31:0] value_out;
        logic        full_res;
        logic [6:0]  entry_count;
    } t_res;

    // hashed request passed from front to back
    typedef struct packed {
        logic [1:0]    op;
        logic [31:0]   key;
        logic [31:0]   value_in;
        logic [BW-1:0] bucket;
    } t_job;

    function automatic logic [31:0] xs16(input logic [31:0] v);
        xs16 = (v >> 16) ^ v;
    endfunction

endpackage

// File: rtl/chkv_ram.sv
// chkv_ram: generic single write port ram with one registered read port
// no dependencies
module chkv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: rtl/chkv_front.sv
// chkv_front: accepts requests and computes the bucket with a staged mixing hash
// depends on chkv_pkg
module chkv_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  chkv_pkg::t_req i_req,
    input  logic          i_q_full,
    output logic          o_busy,
    output logic          o_push,
    output chkv_pkg::t_job o_job
);
    import chkv_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_M1, S_X2, S_M2, S_OUT} t_state;

    t_state      r_state;
    t_req        r_req;
    logic [31:0] r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: if (i_start) begin
                    r_req   <= i_req;
                    r_v     <= xs16(i_req.key);
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_v <= r_v * MIX_MUL;
                    r_state <= S_X2;
                end
                S_X2: begin
                    r_v <= xs16(r_v);
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_v <= r_v * MIX_MUL;
                    r_state <= S_OUT;
                end
                S_OUT: if (!i_q_full) begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_push = (r_state == S_OUT) && !i_q_full;
    always_comb begin
        o_job.op       = r_req.op;
        o_job.key      = r_req.key;
        o_job.value_in = r_req.value_in;
        o_job.bucket   = BW'(xs16(r_v));
    end
endmodule

// File: rtl/chkv_queue.sv
// chkv_queue: two-entry queue of hashed requests between front and back
// depends on chkv_pkg
module chkv_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  chkv_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output chkv_pkg::t_job o_job
);
    import chkv_pkg::*;

    t_job       r_buf [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_buf[r_wp] <= i_job;
                r_wp <= ~r_wp;
            end
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_buf[r_rp];
endmodule

// File: rtl/chkv_back.sv
// chkv_back: walks bucket chains and applies lookup, insert and remove
// depends on chkv_pkg and chkv_ram
module chkv_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  chkv_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_idle,
    output logic           o_done,
    output chkv_pkg::t_res o_res
);
    import chkv_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HREAD, S_HWAIT, S_SREAD, S_SWAIT, S_CHECK, S_ACT, S_DONE
    } t_state;

    t_state        r_state;
    t_job          r_job;
    logic [BW-1:0] r_clr;
    logic [SW-1:0] r_cur, r_prv, r_head, r_next;
    logic [IW-1:0] r_free_idx;
    logic          r_free_ok;
    logic [ENTRIES-1:0] r_free;
    logic [6:0]    r_occ;
    logic [$clog2(ENTRIES+1)-1:0] r_steps;
    t_res          r_res;

    // memory ports
    logic          hd_we;
    logic [BW-1:0] hd_waddr, hd_raddr;
    logic [SW-1:0] hd_wdata, hd_rdata;
    logic [IW-1:0] kv_waddr, kv_raddr;
    logic [31:0]   k_wdata, k_rdata, v_wdata, v_rdata;
    logic          ln_we;
    logic [IW-1:0] ln_waddr;
    logic [SW-1:0] ln_wdata, ln_rdata;
    logic          k_we, v_we;

    chkv_ram #(.WIDTH(SW), .DEPTH(BUCKETS)) u_heads (
        .i_clk, .i_we(hd_we), .i_waddr(hd_waddr), .i_wdata(hd_wdata),
        .i_raddr(hd_raddr), .o_rdata(hd_rdata));
    chkv_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_keys (
        .i_clk, .i_we(k_we), .i_waddr(kv_waddr), .i_wdata(k_wdata),
        .i_raddr(kv_raddr), .o_rdata(k_rdata));
    chkv_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_vals (
        .i_clk, .i_we(v_we), .i_waddr(kv_waddr), .i_wdata(v_wdata),
        .i_raddr(kv_raddr), .o_rdata(v_rdata));
    chkv_ram #(.WIDTH(SW), .DEPTH(ENTRIES)) u_links (
        .i_clk, .i_we(ln_we), .i_waddr(ln_waddr), .i_wdata(ln_wdata),
        .i_raddr(kv_raddr), .o_rdata(ln_rdata));

    // lowest free slot, registered for the next item
    logic [IW-1:0] n_free_idx;
    logic          n_free_ok;
    always_comb begin
        n_free_idx = '0;
        n_free_ok  = 1'b0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                n_free_idx = IW'(i);
                n_free_ok  = 1'b1;
            end
        end
    end

    logic match;
    assign match = (k_rdata == r_job.key);

    always_comb begin
        hd_we    = 1'b0;
        hd_waddr = r_job.bucket;
        hd_wdata = NIL_SLOT;
        hd_raddr = r_job.bucket;
        kv_raddr = r_cur[IW-1:0];
        kv_waddr = r_cur[IW-1:0];
        k_we     = 1'b0;
        v_we     = 1'b0;
        k_wdata  = r_job.key;
        v_wdata  = r_job.value_in;
        ln_we    = 1'b0;
        ln_waddr = r_cur[IW-1:0];
        ln_wdata = NIL_SLOT;
        if (r_state == S_CLEAR) begin
            hd_we    = 1'b1;
            hd_waddr = r_clr;
        end
        if (r_state == S_ACT) begin
            if (r_cur != NIL_SLOT) begin
                if (r_job.op == OP_INSERT) begin
                    v_we = 1'b1;
                end else if (r_job.op == OP_REMOVE) begin
                    if (r_prv != NIL_SLOT) begin
                        ln_we    = 1'b1;
                        ln_waddr = r_prv[IW-1:0];
                        ln_wdata = r_next;
                    end else begin
                        hd_we    = 1'b1;
                        hd_wdata = r_next;
                    end
                end
            end else if (r_job.op == OP_INSERT && r_free_ok) begin
                kv_waddr = r_free_idx;
                k_we     = 1'b1;
                v_we     = 1'b1;
                ln_we    = 1'b1;
                ln_waddr = r_free_idx;
                ln_wdata = r_head;
                hd_we    = 1'b1;
                hd_wdata = SW'(r_free_idx);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_free  <= '1;
            r_occ   <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == BW'(BUCKETS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (!i_q_empty) begin
                    r_job      <= i_job;
                    r_free_idx <= n_free_idx;
                    r_free_ok  <= n_free_ok;
                    r_state    <= S_HREAD;
                end
                S_HREAD: r_state <= S_HWAIT;
                S_HWAIT: begin
                    r_head  <= hd_rdata;
                    r_cur   <= hd_rdata;
                    r_prv   <= NIL_SLOT;
                    r_steps <= '0;
                    r_state <= (r_job.op == OP_INSERT || r_job.op == OP_LOOKUP ||
                                r_job.op == OP_REMOVE) ? S_SREAD : S_ACT;
                    if (!(r_job.op == OP_INSERT || r_job.op == OP_LOOKUP ||
                          r_job.op == OP_REMOVE)) r_cur <= NIL_SLOT;
                end
                S_SREAD: begin
                    if (r_cur == NIL_SLOT) r_state <= S_ACT;
                    else r_state <= S_SWAIT;
                end
                S_SWAIT: r_state <= S_CHECK;
                S_CHECK: begin
                    if (match) begin
                        r_next  <= ln_rdata;
                        r_state <= S_ACT;
                    end else begin
                        r_prv   <= r_cur;
                        r_cur   <= (r_steps == ($bits(r_steps))'(ENTRIES - 1)) ?
                                   NIL_SLOT : ln_rdata;
                        r_steps <= r_steps + 1'b1;
                        r_state <= S_SREAD;
                    end
                end
                S_ACT: begin
                    r_res.hit         <= 1'b0;
                    r_res.value_out   <= '0;
                    r_res.full_res    <= 1'b0;
                    r_res.entry_count <= r_occ;
                    if (r_cur != NIL_SLOT) begin
                        r_res.hit       <= 1'b1;
                        r_res.value_out <= v_rdata;
                        if (r_job.op == OP_REMOVE) begin
                            r_free[r_cur[IW-1:0]] <= 1'b1;
                            r_occ <= r_occ - 1'b1;
                            r_res.entry_count <= r_occ - 1'b1;
                        end
                    end else if (r_job.op == OP_INSERT) begin
                        if (r_free_ok) begin
                            r_free[r_free_idx] <= 1'b0;
                            r_occ <= r_occ + 1'b1;
                            r_res.entry_count <= r_occ + 1'b1;
                        end else begin
                            r_res.full_res <= 1'b1;
                        end
                    end
                    r_state <= S_DONE;
                end
                S_DONE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_pop  = (r_state == S_IDLE) && !i_q_empty;
    assign o_idle = (r_state == S_IDLE);
    assign o_done = (r_state == S_DONE);
    assign o_res  = r_res;

    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= 7'(ENTRIES)) else $error("occupancy above store size");
    a_hit_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_res.hit |-> o_res.value_out == '0) else $error("miss with value");
    a_full_nohit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_res.full_res |-> !o_res.hit) else $error("full with hit");
endmodule

// File: rtl/chained_hash_key_value_table.sv
// chained_hash_key_value_table: top level of the integer keyed hash table
// depends on chkv_pkg, chkv_front, chkv_queue, chkv_back
//
// usage: drive i_req and raise start while busy is low; the request is
// taken at that edge. op selects lookup, insert/replace or remove.
// each request gives exactly one result on o_res, valid for one cycle while
// o_done is high; the receiver cannot stall and must take it then.
// the front hashes the key (xor-shift, multiply, xor-shift, multiply,
// xor-shift) and hands it to a two entry queue once the queue has room; the
// back reads the bucket head, then walks the chain, reading and comparing
// each entry visited, then updates memories and reports. the front takes no
// new request until it has handed the last one to the queue, and it
// overlaps hashing with the walk of the current one in the back; the back
// takes one request at a time, so throughput is set by the back's chain walk.
// after reset the back clears the bucket head memory, one bucket per cycle,
// all BUCKETS of them (1024 by default); requests queue up meanwhile and busy
// stays high once the queue is full.
module chained_hash_key_value_table (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  chkv_pkg::t_req  i_req,
    output logic            busy,
    output logic            o_done,
    output chkv_pkg::t_res  o_res
);
    import chkv_pkg::*;

    logic q_full, q_empty, push, pop, back_idle;
    t_job f_job, q_job;

    chkv_front u_front (
        .i_clk, .i_rst_n, .i_start(start), .i_req, .i_q_full(q_full),
        .o_busy(busy), .o_push(push), .o_job(f_job));
    chkv_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_job(f_job), .i_pop(pop),
        .o_full(q_full), .o_empty(q_empty), .o_job(q_job));
    chkv_back u_back (
        .i_clk, .i_rst_n, .i_q_empty(q_empty), .i_job(q_job), .o_pop(pop),
        .o_idle(back_idle), .o_done, .o_res);

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_empty) else $error("pop of empty queue");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> back_idle) else $error("pop while back busy");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full) else $error("push into full queue");
endmodule
